// ===== hdl/wlsm_pkg.sv =====
// Shared types and constants for the window layer stack manager.
package wlsm_pkg;

    localparam int SLOT_W  = 8;
    localparam int LAYER_W = 9;

    localparam logic [1:0] REQ_ALLOC = 2'd0;
    localparam logic [1:0] REQ_SET   = 2'd1;
    localparam logic [1:0] REQ_FREE  = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_FREE   = 2'd1;
    localparam logic [1:0] ST_NOT_ALLOC = 2'd2;

    localparam logic SLOT_TAKEN = 1'b1;
    localparam logic SLOT_OPEN  = 1'b0;

    localparam logic signed [LAYER_W-1:0] LAYER_NONE = -9'sd1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ALLOC_RD,
        S_ALLOC_CHK,
        S_LOOK,
        S_CLAMP,
        S_PLAN,
        S_SHIFT,
        S_PUT,
        S_DONE
    } t_state;

endpackage

// ===== hdl/wlsm_req_if.sv =====
// Request channel interface of the window layer stack manager.
interface wlsm_req_if
    import wlsm_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic [1:0]                req_type;
    logic [SLOT_W-1:0]         slot_id;
    logic signed [LAYER_W-1:0] requested_layer;

    modport source (output valid, output req_type, output slot_id,
                    output requested_layer, input ready);
    modport sink (input valid, input req_type, input slot_id,
                  input requested_layer, output ready);
endinterface

// ===== hdl/wlsm_rsp_if.sv =====
// Reply channel interface of the window layer stack manager.
interface wlsm_rsp_if
    import wlsm_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic [1:0]                status;
    logic [SLOT_W-1:0]         granted_slot;
    logic signed [LAYER_W-1:0] final_layer;
    logic signed [LAYER_W-1:0] top_layer;
    logic                      redraw_needed;
    logic [SLOT_W-1:0]         map_from_layer;
    logic [SLOT_W-1:0]         redraw_low;
    logic [SLOT_W-1:0]         redraw_high;

    modport source (output valid, output status, output granted_slot,
                    output final_layer, output top_layer, output redraw_needed,
                    output map_from_layer, output redraw_low, output redraw_high,
                    input ready);
    modport sink (input valid, input status, input granted_slot,
                  input final_layer, input top_layer, input redraw_needed,
                  input map_from_layer, input redraw_low, input redraw_high,
                  output ready);
endinterface

// ===== hdl/wlsm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module wlsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/window_layer_stack_manager_top.sv =====
// Top level of the window layer stack manager: sequencer over three table RAMs.
// An allocate request scans the slot-use RAM from slot 0 for an open slot, reading then checking each slot.
// A set-layer or free request steps through the LOOK, CLAMP, PLAN, SHIFT and PUT states as needed;
// the shift moves one layer-table entry per cycle through the layer RAM port.
// One request is worked on at a time; the reply register lets the next word in.
// After reset a clearing pass over all NUM_SLOTS entries empties the slot-use RAM.
module window_layer_stack_manager_top
    import wlsm_pkg::*;
#(
    parameter int NUM_SLOTS = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    wlsm_req_if.sink   i_req,
    wlsm_rsp_if.source o_rsp
);

    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int LD = (NUM_SLOTS < 256) ? NUM_SLOTS : 256;
    localparam int LW = (LD > 1) ? $clog2(LD) : 1;
    localparam logic [SW-1:0] LAST_SLOT = SW'(NUM_SLOTS - 1);

    t_state r_state, n_state;

    logic [1:0]                r_req, n_req;
    logic [SLOT_W-1:0]         r_sid, n_sid;
    logic signed [LAYER_W-1:0] r_rl, n_rl;
    logic [SW-1:0]             r_idx, n_idx;
    logic signed [LAYER_W-1:0] r_old, n_old;
    logic signed [LAYER_W-1:0] r_layer, n_layer;
    logic signed [LAYER_W-1:0] r_top, n_top;
    logic [1:0]                r_status, n_status;
    logic [SLOT_W-1:0]         r_granted, n_granted;
    logic signed [LAYER_W-1:0] r_final, n_final;
    logic                      r_need, n_need;
    logic [SLOT_W-1:0]         r_map, n_map;
    logic [SLOT_W-1:0]         r_low, n_low;
    logic [SLOT_W-1:0]         r_high, n_high;
    logic [LW-1:0]             r_dst, n_dst;
    logic [LW:0]               r_cnt, n_cnt;
    logic                      r_up, n_up;
    logic                      r_put, n_put;
    logic                      r_pv, n_pv;
    logic [LW-1:0]             r_pdst, n_pdst;

    logic                      r_out_valid, n_out_valid;
    logic [1:0]                r_o_status, n_o_status;
    logic [SLOT_W-1:0]         r_o_granted, n_o_granted;
    logic signed [LAYER_W-1:0] r_o_final, n_o_final;
    logic signed [LAYER_W-1:0] r_o_top, n_o_top;
    logic                      r_o_need, n_o_need;
    logic [SLOT_W-1:0]         r_o_map, n_o_map;
    logic [SLOT_W-1:0]         r_o_low, n_o_low;
    logic [SLOT_W-1:0]         r_o_high, n_o_high;

    logic                iu_we, iu_wdata, iu_rdata;
    logic [SW-1:0]       iu_waddr, iu_raddr;
    logic                sl_we;
    logic [LW-1:0]       sl_waddr, sl_raddr;
    logic [LAYER_W-1:0]  sl_wdata, sl_rdata;
    logic                lt_we;
    logic [LW-1:0]       lt_waddr, lt_raddr, lt_wdata, lt_rdata;

    logic signed [9:0] v_old, v_l, v_top, v_rl, v_sl, v_lim, v_cl;

    wlsm_ram #(.WIDTH(1), .DEPTH(NUM_SLOTS)) u_in_use (
        .i_clk  (i_clk),
        .i_we   (iu_we),
        .i_waddr(iu_waddr),
        .i_wdata(iu_wdata),
        .i_raddr(iu_raddr),
        .o_rdata(iu_rdata)
    );

    wlsm_ram #(.WIDTH(LAYER_W), .DEPTH(LD)) u_slot_layer (
        .i_clk  (i_clk),
        .i_we   (sl_we),
        .i_waddr(sl_waddr),
        .i_wdata(sl_wdata),
        .i_raddr(sl_raddr),
        .o_rdata(sl_rdata)
    );

    wlsm_ram #(.WIDTH(LW), .DEPTH(LD)) u_layer_to_slot (
        .i_clk  (i_clk),
        .i_we   (lt_we),
        .i_waddr(lt_waddr),
        .i_wdata(lt_wdata),
        .i_raddr(lt_raddr),
        .o_rdata(lt_rdata)
    );

    assign v_old = $signed({r_old[LAYER_W-1], r_old});
    assign v_l   = $signed({r_layer[LAYER_W-1], r_layer});
    assign v_top = $signed({r_top[LAYER_W-1], r_top});
    assign v_rl  = $signed({r_rl[LAYER_W-1], r_rl});
    assign v_sl  = $signed({sl_rdata[LAYER_W-1], sl_rdata});
    // A shown slot cannot go above the current top; a hidden one may land on top plus one.
    assign v_lim = v_sl[9] ? (v_top + 10'sd1) : v_top;
    assign v_cl  = (v_rl > v_lim) ? v_lim : ((v_rl < -10'sd1) ? -10'sd1 : v_rl);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_idx       <= '0;
            r_top       <= LAYER_NONE;
            r_pv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_top       <= n_top;
            r_pv        <= n_pv;
            r_out_valid <= n_out_valid;
        end
        r_req       <= n_req;
        r_sid       <= n_sid;
        r_rl        <= n_rl;
        r_old       <= n_old;
        r_layer     <= n_layer;
        r_status    <= n_status;
        r_granted   <= n_granted;
        r_final     <= n_final;
        r_need      <= n_need;
        r_map       <= n_map;
        r_low       <= n_low;
        r_high      <= n_high;
        r_dst       <= n_dst;
        r_cnt       <= n_cnt;
        r_up        <= n_up;
        r_put       <= n_put;
        r_pdst      <= n_pdst;
        r_o_status  <= n_o_status;
        r_o_granted <= n_o_granted;
        r_o_final   <= n_o_final;
        r_o_top     <= n_o_top;
        r_o_need    <= n_o_need;
        r_o_map     <= n_o_map;
        r_o_low     <= n_o_low;
        r_o_high    <= n_o_high;
    end

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_sid       = r_sid;
        n_rl        = r_rl;
        n_idx       = r_idx;
        n_old       = r_old;
        n_layer     = r_layer;
        n_top       = r_top;
        n_status    = r_status;
        n_granted   = r_granted;
        n_final     = r_final;
        n_need      = r_need;
        n_map       = r_map;
        n_low       = r_low;
        n_high      = r_high;
        n_dst       = r_dst;
        n_cnt       = r_cnt;
        n_up        = r_up;
        n_put       = r_put;
        n_pv        = r_pv;
        n_pdst      = r_pdst;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_o_status  = r_o_status;
        n_o_granted = r_o_granted;
        n_o_final   = r_o_final;
        n_o_top     = r_o_top;
        n_o_need    = r_o_need;
        n_o_map     = r_o_map;
        n_o_low     = r_o_low;
        n_o_high    = r_o_high;

        iu_we    = 1'b0;
        iu_waddr = r_idx;
        iu_wdata = SLOT_OPEN;
        iu_raddr = r_idx;
        sl_we    = 1'b0;
        sl_waddr = LW'(r_sid);
        sl_wdata = r_layer;
        sl_raddr = LW'(r_sid);
        lt_we    = 1'b0;
        lt_waddr = r_pdst;
        lt_wdata = lt_rdata;
        lt_raddr = r_dst;

        i_req.ready = (r_state == S_IDLE);

        unique case (r_state)
            S_CLEAR: begin
                iu_we    = 1'b1;
                iu_waddr = r_idx;
                iu_wdata = SLOT_OPEN;
                if (r_idx == LAST_SLOT) begin
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    n_req     = i_req.req_type;
                    n_sid     = i_req.slot_id;
                    n_rl      = i_req.requested_layer;
                    n_idx     = '0;
                    n_status  = ST_OK;
                    n_granted = '0;
                    n_final   = LAYER_NONE;
                    n_need    = 1'b0;
                    n_map     = '0;
                    n_low     = '0;
                    n_high    = '0;
                    n_pv      = 1'b0;
                    n_put     = 1'b0;
                    unique case (i_req.req_type)
                        REQ_ALLOC: begin
                            n_state = S_ALLOC_RD;
                        end
                        REQ_SET, REQ_FREE: begin
                            n_granted = i_req.slot_id;
                            if (int'(i_req.slot_id) < NUM_SLOTS) begin
                                n_state = S_LOOK;
                            end else begin
                                n_status = ST_NOT_ALLOC;
                                n_state  = S_DONE;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_ALLOC_RD: begin
                iu_raddr = r_idx;
                n_state  = S_ALLOC_CHK;
            end
            S_ALLOC_CHK: begin
                if (iu_rdata != SLOT_TAKEN) begin
                    iu_we    = 1'b1;
                    iu_waddr = r_idx;
                    iu_wdata = SLOT_TAKEN;
                    if (int'(r_idx) < LD) begin
                        sl_we    = 1'b1;
                        sl_waddr = LW'(r_idx);
                        sl_wdata = LAYER_NONE;
                    end
                    n_status  = ST_OK;
                    n_granted = SLOT_W'(r_idx);
                    n_state   = S_DONE;
                end else if (r_idx == LAST_SLOT) begin
                    n_status  = ST_NO_FREE;
                    n_granted = '0;
                    n_state   = S_DONE;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_ALLOC_RD;
                end
            end
            S_LOOK: begin
                iu_raddr = SW'(r_sid);
                sl_raddr = LW'(r_sid);
                n_state  = S_CLAMP;
            end
            S_CLAMP: begin
                n_old = sl_rdata;
                if (iu_rdata != SLOT_TAKEN) begin
                    n_status = ST_NOT_ALLOC;
                    n_state  = S_DONE;
                end else if (r_req == REQ_FREE) begin
                    iu_we    = 1'b1;
                    iu_waddr = SW'(r_sid);
                    iu_wdata = SLOT_OPEN;
                    n_final  = LAYER_NONE;
                    n_layer  = LAYER_NONE;
                    n_state  = sl_rdata[LAYER_W-1] ? S_DONE : S_PLAN;
                end else begin
                    n_layer = LAYER_W'(v_cl);
                    n_final = LAYER_W'(v_cl);
                    n_state = S_PLAN;
                end
            end
            S_PLAN: begin
                sl_we    = 1'b1;
                sl_waddr = LW'(r_sid);
                sl_wdata = r_layer;
                n_state  = S_DONE;
                if (v_old > v_l) begin
                    if (!r_layer[LAYER_W-1]) begin
                        n_dst  = LW'(r_old);
                        n_cnt  = (LW+1)'(v_old - v_l);
                        n_up   = 1'b0;
                        n_put  = 1'b1;
                        n_need = 1'b1;
                        n_map  = SLOT_W'(v_l + 10'sd1);
                        n_low  = SLOT_W'(v_l + 10'sd1);
                        n_high = SLOT_W'(r_old);
                    end else begin
                        n_dst  = LW'(r_old);
                        n_cnt  = (LW+1)'(v_top - v_old);
                        n_up   = 1'b1;
                        n_put  = 1'b0;
                        n_top  = r_top - 9'sd1;
                        n_need = (r_old != '0);
                        n_map  = '0;
                        n_low  = '0;
                        n_high = (r_old != '0) ? SLOT_W'(v_old - 10'sd1) : '0;
                    end
                    n_state = (n_cnt != '0) ? S_SHIFT : (n_put ? S_PUT : S_DONE);
                end else if (v_old < v_l) begin
                    if (!r_old[LAYER_W-1]) begin
                        n_dst = LW'(r_old);
                        n_cnt = (LW+1)'(v_l - v_old);
                        n_up  = 1'b1;
                    end else begin
                        n_dst = LW'(v_top + 10'sd1);
                        n_cnt = (LW+1)'(v_top + 10'sd1 - v_l);
                        n_up  = 1'b0;
                        n_top = r_top + 9'sd1;
                    end
                    n_put   = 1'b1;
                    n_need  = 1'b1;
                    n_map   = SLOT_W'(r_layer);
                    n_low   = SLOT_W'(r_layer);
                    n_high  = SLOT_W'(r_layer);
                    n_state = (n_cnt != '0) ? S_SHIFT : S_PUT;
                end
            end
            S_SHIFT: begin
                if (r_pv) begin
                    lt_we    = 1'b1;
                    lt_waddr = r_pdst;
                    lt_wdata = lt_rdata;
                    sl_we    = 1'b1;
                    sl_waddr = lt_rdata;
                    sl_wdata = LAYER_W'(r_pdst);
                end
                if (r_cnt != '0) begin
                    lt_raddr = r_up ? (r_dst + 1'b1) : (r_dst - 1'b1);
                    n_pv     = 1'b1;
                    n_pdst   = r_dst;
                    n_dst    = r_up ? (r_dst + 1'b1) : (r_dst - 1'b1);
                    n_cnt    = r_cnt - 1'b1;
                end else begin
                    n_pv    = 1'b0;
                    n_state = r_put ? S_PUT : S_DONE;
                end
            end
            S_PUT: begin
                lt_we    = 1'b1;
                lt_waddr = LW'(r_layer);
                lt_wdata = LW'(r_sid);
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_o_status  = r_status;
                    n_o_granted = r_granted;
                    n_o_final   = r_final;
                    n_o_top     = r_top;
                    n_o_need    = r_need;
                    n_o_map     = r_map;
                    n_o_low     = r_low;
                    n_o_high    = r_high;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.status         = r_o_status;
    assign o_rsp.granted_slot   = r_o_granted;
    assign o_rsp.final_layer    = r_o_final;
    assign o_rsp.top_layer      = r_o_top;
    assign o_rsp.redraw_needed  = r_o_need;
    assign o_rsp.map_from_layer = r_o_map;
    assign o_rsp.redraw_low     = r_o_low;
    assign o_rsp.redraw_high    = r_o_high;

endmodule

// ===== hdl/wlsm_checker.sv =====
// Port-level assertions for the window layer stack manager and their bind.
module wlsm_checker
    import wlsm_pkg::*;
(
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_rsp_valid,
    input logic                      i_rsp_ready,
    input logic [1:0]                i_rsp_status,
    input logic signed [LAYER_W-1:0] i_rsp_final_layer,
    input logic signed [LAYER_W-1:0] i_rsp_top_layer,
    input logic                      i_rsp_redraw_needed,
    input logic [SLOT_W-1:0]         i_rsp_redraw_low,
    input logic [SLOT_W-1:0]         i_rsp_redraw_high
);

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("A reply word appeared right after reset.");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_final_layer))
        else $error("A stalled reply word was dropped or changed.");

    a_error_no_redraw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_status != ST_OK)
            |-> !i_rsp_redraw_needed && (i_rsp_final_layer == LAYER_NONE))
        else $error("A failed request reported a redraw or a shown layer.");

    a_redraw_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_rsp_redraw_needed ? (i_rsp_redraw_low <= i_rsp_redraw_high)
                         : ((i_rsp_redraw_low == '0) && (i_rsp_redraw_high == '0))))
        else $error("The redraw range is inverted or not cleared.");

    a_final_below_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_final_layer != LAYER_NONE)
            |-> (i_rsp_final_layer <= i_rsp_top_layer))
        else $error("A shown slot lies above the top layer.");

endmodule

bind window_layer_stack_manager_top wlsm_checker u_wlsm_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_rsp_valid        (o_rsp.valid),
    .i_rsp_ready        (o_rsp.ready),
    .i_rsp_status       (o_rsp.status),
    .i_rsp_final_layer  (o_rsp.final_layer),
    .i_rsp_top_layer    (o_rsp.top_layer),
    .i_rsp_redraw_needed(o_rsp.redraw_needed),
    .i_rsp_redraw_low   (o_rsp.redraw_low),
    .i_rsp_redraw_high  (o_rsp.redraw_high)
);
